// ----- src/dpdd_pkg.sv -----
// shared types, codes and constants of the dive profile delta decoder
package dpdd_pkg;

  localparam int DEF_MAX_SAMPLES  = 4095;
  localparam int DEF_HEADER_BYTES = 3;
  localparam int HDR_W            = 2;
  localparam int QUEUE_DEPTH      = 4;
  localparam int TIME_W           = 20;
  localparam int DEPTH_W          = 16;

  localparam int SAMPLE_SECONDS = 180;
  localparam int MINUTE_SECONDS = 60;

  localparam logic [7:0] BYTE_ESC_LO   = 8'h7D;
  localparam logic [7:0] BYTE_DECO     = 8'h7E;
  localparam logic [7:0] BYTE_CEILING  = 8'h7F;
  localparam logic [7:0] BYTE_END      = 8'h80;
  localparam logic [7:0] BYTE_ASCENT   = 8'h81;
  localparam logic [7:0] BYTE_IGNORE   = 8'h82;
  localparam logic [7:0] BYTE_ESC_HI   = 8'h83;

  localparam logic [1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [1:0] KIND_EVENT   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  localparam logic [1:0] EVT_DECO    = 2'd0;
  localparam logic [1:0] EVT_CEILING = 2'd1;
  localparam logic [1:0] EVT_ASCENT  = 2'd2;

  localparam logic [1:0] ERR_SHORT   = 2'd0;
  localparam logic [1:0] ERR_ESCAPE  = 2'd1;
  localparam logic [1:0] ERR_NO_END  = 2'd2;
  localparam logic [1:0] ERR_NO_TAIL = 2'd3;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_BODY,
    PH_ESCAPE,
    PH_TAIL,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    OP_DELTA,
    OP_SAMPLE,
    OP_EVENT,
    OP_SUMMARY,
    OP_ERROR
  } op_t;

  // one classified byte handed from front to back
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [1:0] code;   // event or error code
    logic       trail;  // no-end-marker error follows this op
    logic       clear;  // start of a new record: zero the back state first
  } entry_t;

  typedef struct packed {
    logic [1:0]                kind;
    logic [TIME_W-1:0]         time_seconds;
    logic signed [DEPTH_W-1:0] depth_feet;
    logic                      gas_report;
    logic [1:0]                event_code;
    logic [TIME_W-1:0]         dive_time_seconds;
    logic signed [DEPTH_W-1:0] max_depth_feet;
    logic [1:0]                error_code;
    logic                      last_of_run;
  } result_t;

endpackage

// ----- src/dpdd_front.sv -----
// front end: header skipping, phase tracking and byte classification
module dpdd_front #(
  parameter int HEADER_BYTES = dpdd_pkg::DEF_HEADER_BYTES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             record_start,
  input  logic             last_byte,
  output logic             push,
  output dpdd_pkg::entry_t push_entry
);

  localparam logic [dpdd_pkg::HDR_W-1:0] HDR_INIT = dpdd_pkg::HDR_W'(HEADER_BYTES);
  localparam dpdd_pkg::phase_t PH_INIT =
    (HEADER_BYTES == 0) ? dpdd_pkg::PH_BODY : dpdd_pkg::PH_HEADER;

  dpdd_pkg::phase_t              phase_r, phase_nxt, phase_eff;
  logic [dpdd_pkg::HDR_W-1:0]    hdr_left_r, hdr_left_nxt, hdr_eff, hdr_dec;
  logic                          clear_pend_r, clear_pend_nxt;
  logic                          is_delta, is_escape, is_end;

  always_comb begin
    phase_eff = record_start ? PH_INIT : phase_r;
    hdr_eff   = record_start ? HDR_INIT : hdr_left_r;
    hdr_dec   = (hdr_eff != '0) ? hdr_eff - 1'b1 : hdr_eff;
    is_end    = (data_byte == dpdd_pkg::BYTE_END);
    is_delta  = (data_byte < dpdd_pkg::BYTE_DECO) || (data_byte > dpdd_pkg::BYTE_IGNORE);
    is_escape = (data_byte == dpdd_pkg::BYTE_ESC_LO) || (data_byte == dpdd_pkg::BYTE_ESC_HI);
  end

  // next phase
  always_comb begin
    phase_nxt    = phase_r;
    hdr_left_nxt = hdr_left_r;
    if (accept) begin
      hdr_left_nxt = hdr_eff;
      case (phase_eff)
        dpdd_pkg::PH_HEADER: begin
          hdr_left_nxt = hdr_dec;
          if (last_byte) phase_nxt = dpdd_pkg::PH_DONE;
          else if (hdr_dec == '0) phase_nxt = dpdd_pkg::PH_BODY;
          else phase_nxt = dpdd_pkg::PH_HEADER;
        end
        dpdd_pkg::PH_BODY: begin
          if (last_byte) phase_nxt = dpdd_pkg::PH_DONE;
          else if (is_end) phase_nxt = dpdd_pkg::PH_TAIL;
          else if (is_delta && is_escape) phase_nxt = dpdd_pkg::PH_ESCAPE;
          else phase_nxt = dpdd_pkg::PH_BODY;
        end
        dpdd_pkg::PH_ESCAPE: begin
          phase_nxt = last_byte ? dpdd_pkg::PH_DONE : dpdd_pkg::PH_BODY;
        end
        dpdd_pkg::PH_TAIL: phase_nxt = dpdd_pkg::PH_DONE;
        default:           phase_nxt = dpdd_pkg::PH_DONE;
      endcase
    end
  end

  // classification into back-end operations
  always_comb begin
    push             = 1'b0;
    push_entry.op    = dpdd_pkg::OP_DELTA;
    push_entry.data  = data_byte;
    push_entry.code  = dpdd_pkg::ERR_SHORT;
    push_entry.trail = 1'b0;
    push_entry.clear = record_start | clear_pend_r;
    case (phase_eff)
      dpdd_pkg::PH_HEADER: begin
        if (last_byte) begin
          push            = 1'b1;
          push_entry.op   = dpdd_pkg::OP_ERROR;
          push_entry.code = dpdd_pkg::ERR_SHORT;
        end
      end
      dpdd_pkg::PH_BODY: begin
        if (is_end) begin
          if (last_byte) begin
            push            = 1'b1;
            push_entry.op   = dpdd_pkg::OP_ERROR;
            push_entry.code = dpdd_pkg::ERR_NO_TAIL;
          end
        end else if (is_delta) begin
          push = 1'b1;
          if (is_escape) begin
            if (last_byte) begin
              push_entry.op   = dpdd_pkg::OP_ERROR;
              push_entry.code = dpdd_pkg::ERR_ESCAPE;
            end else begin
              push_entry.op = dpdd_pkg::OP_DELTA;
            end
          end else begin
            push_entry.op    = dpdd_pkg::OP_SAMPLE;
            push_entry.trail = last_byte;
          end
        end else if (data_byte == dpdd_pkg::BYTE_IGNORE) begin
          if (last_byte) begin
            push            = 1'b1;
            push_entry.op   = dpdd_pkg::OP_ERROR;
            push_entry.code = dpdd_pkg::ERR_NO_END;
          end
        end else begin
          push             = 1'b1;
          push_entry.op    = dpdd_pkg::OP_EVENT;
          push_entry.trail = last_byte;
          if (data_byte == dpdd_pkg::BYTE_DECO) push_entry.code = dpdd_pkg::EVT_DECO;
          else if (data_byte == dpdd_pkg::BYTE_CEILING) push_entry.code = dpdd_pkg::EVT_CEILING;
          else push_entry.code = dpdd_pkg::EVT_ASCENT;
        end
      end
      dpdd_pkg::PH_ESCAPE: begin
        push             = 1'b1;
        push_entry.op    = dpdd_pkg::OP_SAMPLE;
        push_entry.trail = last_byte;
      end
      dpdd_pkg::PH_TAIL: begin
        push          = 1'b1;
        push_entry.op = dpdd_pkg::OP_SUMMARY;
      end
      default: push = 1'b0;
    endcase
    push = push & accept;
  end

  // a record start whose byte pushes nothing hands its clear to the next push
  always_comb begin
    clear_pend_nxt = clear_pend_r;
    if (accept) clear_pend_nxt = push ? 1'b0 : (record_start | clear_pend_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_INIT;
      hdr_left_r   <= HDR_INIT;
      clear_pend_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      hdr_left_r   <= hdr_left_nxt;
      clear_pend_r <= clear_pend_nxt;
    end
  end

endmodule

// ----- src/dpdd_queue.sv -----
// short queue of classified bytes between front and back
module dpdd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dpdd_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output dpdd_pkg::entry_t head
);

  localparam int PTR_W = $clog2(dpdd_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(dpdd_pkg::QUEUE_DEPTH + 1);

  dpdd_pkg::entry_t   mem [dpdd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full       = (count_r == CNT_W'(dpdd_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- src/dpdd_back.sv -----
// back end: depth accumulation, sample counting and result register
module dpdd_back #(
  parameter int MAX_SAMPLES = dpdd_pkg::DEF_MAX_SAMPLES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  dpdd_pkg::entry_t  head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output dpdd_pkg::result_t out_res
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int DW    = dpdd_pkg::DEPTH_W;

  logic signed [DW-1:0] depth_r, depth_nxt, deep_r, deep_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 gas_r, gas_nxt;
  logic                 pend_r, pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  dpdd_pkg::result_t    out_res_r, res;
  logic                 res_valid;

  logic signed [DW-1:0] base_depth, base_deep, sum_depth;
  logic [CNT_W-1:0]     base_cnt, inc_cnt;
  logic                 base_gas, load, two;
  logic [31:0]          time_prod, dive_prod;

  assign load = head_valid && (!out_valid_r || out_ready);
  assign two  = head.trail &&
                ((head.op == dpdd_pkg::OP_SAMPLE) || (head.op == dpdd_pkg::OP_EVENT));
  assign pop  = load && (pend_r || !two);

  always_comb begin
    base_depth = head.clear ? '0 : depth_r;
    base_deep  = head.clear ? '0 : deep_r;
    base_cnt   = head.clear ? '0 : cnt_r;
    base_gas   = head.clear ? 1'b0 : gas_r;
    sum_depth  = base_depth + DW'(signed'(head.data));
    inc_cnt    = (base_cnt < CNT_W'(MAX_SAMPLES)) ? base_cnt + 1'b1 : base_cnt;
    time_prod  = 32'(inc_cnt) * 32'(dpdd_pkg::SAMPLE_SECONDS);
    dive_prod  = 32'(base_cnt) * 32'(dpdd_pkg::SAMPLE_SECONDS)
               + 32'(head.data) * 32'(dpdd_pkg::MINUTE_SECONDS);
  end

  always_comb begin
    depth_nxt = depth_r;
    deep_nxt  = deep_r;
    cnt_nxt   = cnt_r;
    gas_nxt   = gas_r;
    pend_nxt  = pend_r;
    res       = '0;
    res_valid = 1'b0;
    if (load) begin
      if (pend_r) begin
        // second result of a byte: the missing end marker
        res_valid       = 1'b1;
        res.kind        = dpdd_pkg::KIND_ERROR;
        res.error_code  = dpdd_pkg::ERR_NO_END;
        res.last_of_run = 1'b1;
        pend_nxt        = 1'b0;
      end else begin
        depth_nxt = base_depth;
        deep_nxt  = base_deep;
        cnt_nxt   = base_cnt;
        gas_nxt   = base_gas;
        pend_nxt  = two;
        case (head.op)
          dpdd_pkg::OP_DELTA: depth_nxt = sum_depth;
          dpdd_pkg::OP_SAMPLE: begin
            depth_nxt        = sum_depth;
            deep_nxt         = (sum_depth > base_deep) ? sum_depth : base_deep;
            cnt_nxt          = inc_cnt;
            gas_nxt          = 1'b1;
            res_valid        = 1'b1;
            res.kind         = dpdd_pkg::KIND_SAMPLE;
            res.time_seconds = time_prod[dpdd_pkg::TIME_W-1:0];
            res.depth_feet   = sum_depth;
            res.gas_report   = !base_gas;
            res.last_of_run  = !two;
          end
          dpdd_pkg::OP_EVENT: begin
            res_valid       = 1'b1;
            res.kind        = dpdd_pkg::KIND_EVENT;
            res.event_code  = head.code;
            res.last_of_run = !two;
          end
          dpdd_pkg::OP_SUMMARY: begin
            res_valid             = 1'b1;
            res.kind              = dpdd_pkg::KIND_SUMMARY;
            res.dive_time_seconds = dive_prod[dpdd_pkg::TIME_W-1:0];
            res.max_depth_feet    = base_deep;
            res.last_of_run       = 1'b1;
          end
          dpdd_pkg::OP_ERROR: begin
            res_valid       = 1'b1;
            res.kind        = dpdd_pkg::KIND_ERROR;
            res.error_code  = head.code;
            res.last_of_run = 1'b1;
          end
          default: res_valid = 1'b0;
        endcase
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) out_valid_nxt = res_valid;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) out_res_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      deep_r      <= '0;
      cnt_r       <= '0;
      gas_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      depth_r     <= depth_nxt;
      deep_r      <= deep_nxt;
      cnt_r       <= cnt_nxt;
      gas_r       <= gas_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTH
  a_pend_holds_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> head_valid)
    else $error("second result pending without a queued entry");

  a_error_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.kind == dpdd_pkg::KIND_ERROR) |-> out_res_r.last_of_run)
    else $error("error result not marked last of run");

  a_open_run_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.last_of_run) |-> pend_r)
    else $error("open run without a pending trailing error");

  a_max_tracks_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.kind == dpdd_pkg::KIND_SAMPLE) |-> (deep_r >= depth_r))
    else $error("deepest below running depth after a sample");
`endif

endmodule

// ----- src/dive_profile_delta_decoder_unit.sv -----
// top level of the dive profile delta decoder: stream ports, front, queue and back
// path: an accepted byte is queued, and its result is registered at the output
// throughput: one byte per cycle while the queue is not full; a byte with two
//   results pops with its second; the four-entry queue absorbs the difference
// reset: rst_n synchronous, active low; clears phase, queue pointers, running state
//   and the output valid; no clearing pass
module dive_profile_delta_decoder_unit #(
  parameter int MAX_SAMPLES  = dpdd_pkg::DEF_MAX_SAMPLES,
  parameter int HEADER_BYTES = dpdd_pkg::DEF_HEADER_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // record_start
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // time_seconds[19:0], depth_feet[35:20], gas_report[36], event_code[38:37],
  // dive_time_seconds[58:39], max_depth_feet[74:59], error_code[76:75], zero[79:77]
  output logic [79:0] out_tdata,
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast   // last_of_run
);

  logic              accept, push, full, head_valid, pop;
  dpdd_pkg::entry_t  push_entry, head;
  dpdd_pkg::result_t res;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  dpdd_front #(.HEADER_BYTES(HEADER_BYTES)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_tdata),
    .record_start (in_tuser),
    .last_byte    (in_tlast),
    .push         (push),
    .push_entry   (push_entry)
  );

  dpdd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  dpdd_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {3'b000, res.error_code, res.max_depth_feet, res.dive_time_seconds,
                      res.event_code, res.gas_report, res.depth_feet, res.time_seconds};
  assign out_tuser = res.kind;
  assign out_tlast = res.last_of_run;

endmodule
